// ===== rtl/core/kaf_pkg.sv =====
// Shared types, codes and the step program of the IMU angle Kalman filter.
package kaf_pkg;

  localparam int unsigned WordW = 32;
  localparam int unsigned AccW  = 40;
  localparam int unsigned ProdW = 66;
  localparam int unsigned DenW  = 34;
  localparam int unsigned PcW   = 5;

  // Datapath operations.
  localparam logic [3:0] OP_IDLE  = 4'd0;
  localparam logic [3:0] OP_LOAD  = 4'd1;
  localparam logic [3:0] OP_MUL   = 4'd2;
  localparam logic [3:0] OP_ADD   = 4'd3;
  localparam logic [3:0] OP_SUB   = 4'd4;
  localparam logic [3:0] OP_PREP  = 4'd5;
  localparam logic [3:0] OP_DIV0  = 4'd6;
  localparam logic [3:0] OP_DIV1  = 4'd7;
  localparam logic [3:0] OP_FINAL = 4'd8;

  // Multiplier first operand.
  localparam logic [2:0] A_RATE = 3'd0;
  localparam logic [2:0] A_D0   = 3'd1;
  localparam logic [2:0] A_D1   = 3'd2;
  localparam logic [2:0] A_D3   = 3'd3;
  localparam logic [2:0] A_K0   = 3'd4;
  localparam logic [2:0] A_K1   = 3'd5;

  // Multiplier second operand.
  localparam logic [1:0] B_DT  = 2'd0;
  localparam logic [1:0] B_T0  = 2'd1;
  localparam logic [1:0] B_T1  = 2'd2;
  localparam logic [1:0] B_ERR = 2'd3;

  // Accumulate destination.
  localparam logic [2:0] D_ANGLE = 3'd0;
  localparam logic [2:0] D_BIAS  = 3'd1;
  localparam logic [2:0] D_P0    = 3'd2;
  localparam logic [2:0] D_P1    = 3'd3;
  localparam logic [2:0] D_P2    = 3'd4;
  localparam logic [2:0] D_P3    = 3'd5;

  // Configuration register indexes.
  localparam logic [1:0] REG_TIME_STEP = 2'd0;
  localparam logic [1:0] REG_ANGLE_Q   = 2'd1;
  localparam logic [1:0] REG_BIAS_Q    = 2'd2;
  localparam logic [1:0] REG_MEAS_R    = 2'd3;

  localparam logic [WordW-1:0] ONE_Q28 = 32'd268435456;

  localparam logic [PcW-1:0] LAST_PC = 5'd25;

  typedef struct packed {
    logic [3:0] op;
    logic [2:0] asel;
    logic [1:0] bsel;
    logic [2:0] dsel;
  } kaf_cmd_t;

  typedef struct packed {
    logic div_done;
    logic out_full;
  } kaf_status_t;

  function automatic logic signed [WordW-1:0] sat32(input logic signed [AccW-1:0] v);
    logic signed [AccW-1:0] hi;
    logic signed [AccW-1:0] lo;
    hi = AccW'(signed'(33'sh0_7fff_ffff));
    lo = -hi - AccW'(1);
    if (v > hi) begin
      return 32'h7fff_ffff;
    end else if (v < lo) begin
      return 32'h8000_0000;
    end
    return v[WordW-1:0];
  endfunction

  function automatic kaf_cmd_t mk(input logic [3:0] op, input logic [2:0] a,
                                  input logic [1:0] b, input logic [2:0] d);
    kaf_cmd_t c;
    c.op = op;
    c.asel = a;
    c.bsel = b;
    c.dsel = d;
    return c;
  endfunction

  // One filter update as a fixed sequence of datapath steps.
  function automatic kaf_cmd_t program_step(input logic [PcW-1:0] pc);
    case (pc)
      5'd0:  return mk(OP_LOAD,  A_RATE, B_DT,  D_ANGLE);
      5'd1:  return mk(OP_MUL,   A_RATE, B_DT,  D_ANGLE);
      5'd2:  return mk(OP_ADD,   A_RATE, B_DT,  D_ANGLE);
      5'd3:  return mk(OP_MUL,   A_D0,   B_DT,  D_P0);
      5'd4:  return mk(OP_ADD,   A_D0,   B_DT,  D_P0);
      5'd5:  return mk(OP_MUL,   A_D1,   B_DT,  D_P1);
      5'd6:  return mk(OP_ADD,   A_D1,   B_DT,  D_P1);
      5'd7:  return mk(OP_ADD,   A_D1,   B_DT,  D_P2);
      5'd8:  return mk(OP_MUL,   A_D3,   B_DT,  D_P3);
      5'd9:  return mk(OP_ADD,   A_D3,   B_DT,  D_P3);
      5'd10: return mk(OP_PREP,  A_RATE, B_DT,  D_ANGLE);
      5'd11: return mk(OP_DIV0,  A_RATE, B_DT,  D_ANGLE);
      5'd12: return mk(OP_DIV1,  A_RATE, B_DT,  D_ANGLE);
      5'd13: return mk(OP_MUL,   A_K0,   B_T0,  D_P0);
      5'd14: return mk(OP_SUB,   A_K0,   B_T0,  D_P0);
      5'd15: return mk(OP_MUL,   A_K0,   B_T1,  D_P1);
      5'd16: return mk(OP_SUB,   A_K0,   B_T1,  D_P1);
      5'd17: return mk(OP_MUL,   A_K1,   B_T0,  D_P2);
      5'd18: return mk(OP_SUB,   A_K1,   B_T0,  D_P2);
      5'd19: return mk(OP_MUL,   A_K1,   B_T1,  D_P3);
      5'd20: return mk(OP_SUB,   A_K1,   B_T1,  D_P3);
      5'd21: return mk(OP_MUL,   A_K0,   B_ERR, D_ANGLE);
      5'd22: return mk(OP_ADD,   A_K0,   B_ERR, D_ANGLE);
      5'd23: return mk(OP_MUL,   A_K1,   B_ERR, D_BIAS);
      5'd24: return mk(OP_ADD,   A_K1,   B_ERR, D_BIAS);
      5'd25: return mk(OP_FINAL, A_RATE, B_DT,  D_ANGLE);
      default: return mk(OP_IDLE, A_RATE, B_DT, D_ANGLE);
    endcase
  endfunction

endpackage

// ===== rtl/core/kaf_div.sv =====
// Radix-2 restoring divider that forms a saturated Q4.28 gain P * 2^28 / E.
module kaf_div (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             start,
  input  logic signed [kaf_pkg::WordW-1:0] num,
  input  logic signed [kaf_pkg::DenW-1:0]  den,
  output logic                             done,
  output logic signed [kaf_pkg::WordW-1:0] quo
);
  import kaf_pkg::*;

  localparam int unsigned DvdW = WordW + 28;

  logic            busy;
  logic [5:0]      count;
  logic [DvdW-1:0] dvd;
  logic [DenW:0]   rem;
  logic [DenW-1:0] dmag;
  logic            neg;
  logic [DenW:0]   trial;
  logic            fit;
  logic [DvdW-1:0] q_final;

  assign trial = {rem[DenW-1:0], dvd[DvdW-1]};
  assign fit = trial >= {1'b0, dmag};
  assign q_final = {dvd[DvdW-2:0], fit};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      count <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= (den != '0);
        done <= (den == '0);
        count <= '0;
      end else if (busy) begin
        count <= count + 6'd1;
        if (count == 6'(DvdW - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      dvd <= {(num[WordW-1] ? WordW'(-num) : WordW'(num)), 28'd0};
      dmag <= den[DenW-1] ? DenW'(-den) : DenW'(den);
      rem <= '0;
      neg <= num[WordW-1] ^ den[DenW-1];
      // A zero divisor gives a zero gain, ready together with done.
      if (den == '0) begin
        quo <= '0;
      end
    end else if (busy) begin
      rem <= fit ? (trial - {1'b0, dmag}) : trial;
      dvd <= q_final;
      if (count == 6'(DvdW - 1)) begin
        if (neg) begin
          quo <= (q_final > DvdW'(33'h0_8000_0000)) ? 32'h8000_0000 :
                 WordW'(-q_final);
        end else begin
          quo <= (q_final > DvdW'(32'h7fff_ffff)) ? 32'h7fff_ffff :
                 q_final[WordW-1:0];
        end
      end
    end
  end

endmodule

// ===== rtl/core/kaf_datapath.sv =====
// Filter state, shared multiplier, accumulate unit, gain divider and output register.
module kaf_datapath (
  input  logic                        clk,
  input  logic                        rst,
  input  kaf_pkg::kaf_cmd_t           cmd,
  output kaf_pkg::kaf_status_t        status,
  input  logic [63:0]                 in_data,
  input  logic                        cfg_we,
  input  logic [1:0]                  cfg_index,
  input  logic [31:0]                 cfg_data,
  output logic                        out_valid,
  input  logic                        out_ready,
  output logic [63:0]                 out_data
);
  import kaf_pkg::*;

  logic [WordW-1:0] dt, qa, qb, rm;
  logic signed [WordW-1:0] angle, bias, p0, p1, p2, p3;
  logic signed [WordW-1:0] accel, gyro, rate, d0, d1, d3, err, t0, t1, k0, k1;
  logic signed [DenW-1:0] e;
  logic signed [ProdW-1:0] prod;
  logic signed [WordW:0] ma, mb;
  logic signed [ProdW-1:0] rnd;
  logic signed [AccW-1:0] resc;
  logic signed [WordW-1:0] dest;
  logic signed [AccW-1:0] sum;
  logic signed [WordW-1:0] acc;
  logic signed [WordW-1:0] in_accel, in_gyro;
  logic div_start, div_done, div_to_k1;
  logic signed [WordW-1:0] div_num, quo;

  assign in_accel = in_data[31:0];
  assign in_gyro = in_data[63:32];

  always_comb begin
    case (cmd.asel)
      A_RATE:  ma = 33'(rate);
      A_D0:    ma = 33'(d0);
      A_D1:    ma = 33'(d1);
      A_D3:    ma = 33'(d3);
      A_K0:    ma = 33'(k0);
      A_K1:    ma = 33'(k1);
      default: ma = '0;
    endcase
    case (cmd.bsel)
      B_DT:    mb = signed'({1'b0, dt});
      B_T0:    mb = 33'(t0);
      B_T1:    mb = 33'(t1);
      B_ERR:   mb = 33'(err);
      default: mb = '0;
    endcase
    case (cmd.dsel)
      D_ANGLE: dest = angle;
      D_BIAS:  dest = bias;
      D_P0:    dest = p0;
      D_P1:    dest = p1;
      D_P2:    dest = p2;
      D_P3:    dest = p3;
      default: dest = '0;
    endcase
  end

  // Round half up while dropping the 28 fraction bits of the product.
  assign rnd = (prod + ProdW'(signed'(29'sh0800_0000))) >>> 28;
  assign resc = rnd[AccW-1:0];
  assign sum = (cmd.op == OP_SUB) ? (AccW'(dest) - resc) : (AccW'(dest) + resc);
  assign acc = sat32(sum);

  assign div_start = (cmd.op == OP_DIV0) || (cmd.op == OP_DIV1);
  assign div_num = (cmd.op == OP_DIV1) ? p2 : p0;

  kaf_div u_div (
    .clk   (clk),
    .rst   (rst),
    .start (div_start),
    .num   (div_num),
    .den   (e),
    .done  (div_done),
    .quo   (quo)
  );

  assign status.div_done = div_done;
  assign status.out_full = out_valid && !out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      dt <= 32'd1342177;
      qa <= 32'd268435;
      qb <= 32'd805306;
      rm <= 32'd134217728;
      angle <= '0;
      bias <= '0;
      p0 <= ONE_Q28;
      p1 <= '0;
      p2 <= '0;
      p3 <= ONE_Q28;
      out_valid <= 1'b0;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          REG_TIME_STEP: dt <= cfg_data;
          REG_ANGLE_Q:   qa <= cfg_data;
          REG_BIAS_Q:    qb <= cfg_data;
          REG_MEAS_R:    rm <= cfg_data;
          default:       dt <= dt;
        endcase
      end
      if (cmd.op == OP_FINAL) begin
        out_valid <= 1'b1;
      end else if (out_valid && out_ready) begin
        out_valid <= 1'b0;
      end
      case (cmd.op)
        OP_ADD, OP_SUB: begin
          case (cmd.dsel)
            D_ANGLE: angle <= acc;
            D_BIAS:  bias <= acc;
            D_P0:    p0 <= acc;
            D_P1:    p1 <= acc;
            D_P2:    p2 <= acc;
            D_P3:    p3 <= acc;
            default: angle <= angle;
          endcase
        end
        default: begin
          angle <= angle;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    case (cmd.op)
      OP_LOAD: begin
        accel <= in_accel;
        gyro <= in_gyro;
        rate <= sat32(AccW'(in_gyro) - AccW'(bias));
        d0 <= sat32(AccW'({1'b0, qa}) - AccW'(p1) - AccW'(p2));
        d1 <= sat32(-AccW'(p3));
        d3 <= sat32(AccW'({1'b0, qb}));
      end
      OP_MUL: begin
        prod <= ma * mb;
      end
      OP_PREP: begin
        err <= sat32(AccW'(accel) - AccW'(angle));
        t0 <= p0;
        t1 <= p1;
        e <= signed'(DenW'({1'b0, rm})) + DenW'(p0);
      end
      OP_DIV0: div_to_k1 <= 1'b0;
      OP_DIV1: div_to_k1 <= 1'b1;
      OP_FINAL: begin
        out_data <= {sat32(AccW'(gyro) - AccW'(bias)), angle};
      end
      default: begin
        prod <= prod;
      end
    endcase
    if (div_done) begin
      if (div_to_k1) begin
        k1 <= quo;
      end else begin
        k0 <= quo;
      end
    end
  end

endmodule

// ===== rtl/core/kaf_ctrl.sv =====
// Step sequencer that walks the datapath through one filter update.
module kaf_ctrl (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  kaf_pkg::kaf_status_t status,
  output kaf_pkg::kaf_cmd_t    cmd
);
  import kaf_pkg::*;

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_RUN  = 2'd1;
  localparam logic [1:0] ST_WAIT = 2'd2;

  logic [1:0] state, state_next;
  logic [PcW-1:0] pc, pc_next;
  kaf_cmd_t step;

  assign step = program_step(pc);
  assign in_ready = (state == ST_IDLE);

  always_comb begin
    state_next = state;
    pc_next = pc;
    cmd = mk(OP_IDLE, A_RATE, B_DT, D_ANGLE);
    case (state)
      ST_IDLE: begin
        if (in_valid) begin
          cmd = program_step('0);
          pc_next = 5'd1;
          state_next = ST_RUN;
        end
      end
      ST_RUN: begin
        if (step.op == OP_DIV0 || step.op == OP_DIV1) begin
          cmd = step;
          state_next = ST_WAIT;
        end else if (step.op == OP_FINAL) begin
          // The output register must be free before the result is written.
          if (!status.out_full) begin
            cmd = step;
            pc_next = '0;
            state_next = ST_IDLE;
          end
        end else begin
          cmd = step;
          pc_next = pc + 5'd1;
        end
      end
      ST_WAIT: begin
        if (status.div_done) begin
          pc_next = pc + 5'd1;
          state_next = ST_RUN;
        end
      end
      default: begin
        state_next = ST_IDLE;
        pc_next = '0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      pc <= '0;
    end else begin
      state <= state_next;
      pc <= pc_next;
    end
  end

  pc_in_range: assert property (@(posedge clk) disable iff (rst) pc <= LAST_PC)
    else $error("step counter past end of program");
  idle_at_start: assert property (@(posedge clk) disable iff (rst)
    state == ST_IDLE |-> pc == '0)
    else $error("idle with step counter not at start");
  done_when_waiting: assert property (@(posedge clk) disable iff (rst)
    status.div_done |-> state == ST_WAIT)
    else $error("divider finished outside a wait");

endmodule

// ===== rtl/core/imu_angle_kalman_filter.sv =====
// Top level of the IMU angle Kalman filter.
// One transaction on the input stream yields one result transaction. An update
// runs 24 sequencer steps on one shared 33x33 multiplier, plus two gain
// divisions that each hold the sequencer while the divider forms one quotient
// bit a cycle over the 60-bit dividend, plus issue and handoff; when the
// innovation variance is zero, a division holds it only for issue and handoff.
// A new input is taken once the previous update is done, even while its result
// still waits in the output register; the next update then stalls before its
// final step until that register is free.
module imu_angle_kalman_filter (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [63:0] s_axis_tdata,  // accel_angle [31:0], gyro_rate [63:32]
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [63:0] m_axis_tdata,  // angle_estimate [31:0], rate_estimate [63:32]
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [31:0] cfg_data
);
  import kaf_pkg::*;

  kaf_cmd_t cmd;
  kaf_status_t status;

  kaf_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (s_axis_tvalid),
    .in_ready (s_axis_tready),
    .status   (status),
    .cmd      (cmd)
  );

  kaf_datapath u_dp (
    .clk       (clk),
    .rst       (rst),
    .cmd       (cmd),
    .status    (status),
    .in_data   (s_axis_tdata),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .out_valid (m_axis_tvalid),
    .out_ready (m_axis_tready),
    .out_data  (m_axis_tdata)
  );

endmodule
